// File: rtl/bdss_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and slot tables of the bitplane dma slot sequencer
package bdss_pkg;

  typedef enum logic [1:0] {
    CMD_SLOT_TICK = 2'd0,
    CMD_NEW_LINE  = 2'd1,
    CMD_PTR_WRITE = 2'd2,
    CMD_RESERVED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_FETCH      = 2'd1,
    ACT_BACKGROUND = 2'd2
  } act_t;

  // configuration register indexes
  localparam logic [2:0] CFG_DMA_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_HIRES_MODE  = 3'd1;
  localparam logic [2:0] CFG_PLANE_COUNT = 3'd2;
  localparam logic [2:0] CFG_EVEN_MOD    = 3'd3;
  localparam logic [2:0] CFG_ODD_MOD     = 3'd4;

  localparam logic [2:0] NO_PLANE   = 3'd7;
  localparam logic [2:0] PLANE_LIMIT = 3'd6;

  // slot decision handed from the slot controller to the datapath
  typedef struct packed {
    logic       used;
    act_t       action;
    logic [2:0] plane;
  } slot_t;

  // pointer file request for the transaction being worked on
  typedef struct packed {
    logic       bump;
    logic       new_line;
    logic       load;
    logic [2:0] plane;
  } ptr_req_t;

  function automatic logic [2:0] lowres_plane(input logic [2:0] slot);
    logic [2:0] p;
    case (slot)
      3'd0:    p = NO_PLANE;
      3'd1:    p = 3'd3;
      3'd2:    p = 3'd5;
      3'd3:    p = 3'd1;
      3'd4:    p = NO_PLANE;
      3'd5:    p = 3'd2;
      3'd6:    p = 3'd4;
      3'd7:    p = 3'd0;
      default: p = NO_PLANE;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] hires_plane(input logic [2:0] slot);
    logic [2:0] p;
    case (slot[1:0])
      2'd0:    p = 3'd3;
      2'd1:    p = 3'd1;
      2'd2:    p = 3'd2;
      2'd3:    p = 3'd0;
      default: p = NO_PLANE;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/bdss_slot_ctrl.sv
`timescale 1ns / 1ps
// fetch run flag, slot counter and per-slot plane decision
module bdss_slot_ctrl import bdss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       dma_enable,
  input  logic       hires_mode,
  input  logic [2:0] plane_count,
  input  logic       window_open,
  input  logic       fetch_begin,
  output slot_t      slot
);

  logic       fetch_active_r, fetch_active_nxt;
  logic [2:0] slot_cnt_r, slot_cnt_nxt;

  always_comb begin
    logic       fa;
    logic       show;
    logic [2:0] cnt;
    logic [2:0] p;
    fa          = fetch_active_r;
    cnt         = slot_cnt_r;
    show        = 1'b1;
    p           = NO_PLANE;
    slot.used   = 1'b0;
    slot.action = ACT_BACKGROUND;
    slot.plane  = 3'd0;
    if (dma_enable && plane_count != 3'd0) begin
      if (!fa) begin
        show = window_open;
        fa   = fetch_begin;
        cnt  = 3'd0;
      end
      if (fa) begin
        p           = hires_mode ? hires_plane(cnt) : lowres_plane(cnt);
        cnt         = cnt + 3'd1;
        slot.action = ACT_NONE;
        if (p < plane_count) begin
          // plane 0 closes the run
          if (p == 3'd0) fa = 1'b0;
          slot.action = show ? ACT_FETCH : ACT_BACKGROUND;
          slot.plane  = p;
          slot.used   = 1'b1;
        end
      end
    end
    fetch_active_nxt = step_en ? fa : fetch_active_r;
    slot_cnt_nxt     = step_en ? cnt : slot_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_active_r <= 1'b0;
      slot_cnt_r     <= 3'd0;
    end else begin
      fetch_active_r <= fetch_active_nxt;
      slot_cnt_r     <= slot_cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_plane0_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && slot.used && slot.plane == 3'd0 |=> !fetch_active_r)
    else $error("run still active after plane 0 slot");

  a_idle_resets_counter: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !fetch_active_r && dma_enable && plane_count != 3'd0 && !fetch_begin
    |=> slot_cnt_r == $past(slot_cnt_r) || slot_cnt_r == 3'd0)
    else $error("slot counter moved while idle");

  a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot.used |-> slot.plane < plane_count && slot.action != ACT_NONE)
    else $error("slot served an inactive plane");
`endif

endmodule

// File: rtl/bdss_ptr_file.sv
`timescale 1ns / 1ps
// bitplane pointer registers with bump, line modulo add and load
module bdss_ptr_file import bdss_pkg::*; #(
  parameter int MAX_PLANES   = 6,
  parameter int ADDRESS_BITS = 24
) (
  input  logic               clk,
  input  ptr_req_t           req,
  input  logic [2:0]         plane_count,
  input  logic signed [15:0] even_mod,
  input  logic signed [15:0] odd_mod,
  input  logic [23:0]        wr_value,
  output logic [23:0]        rd_addr
);

  localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam logic [2:0] NPL = 3'(MAX_PLANES);

  logic [ADDRESS_BITS-1:0] ptr_r [MAX_PLANES];
  logic [ADDRESS_BITS-1:0] even_ext, odd_ext, load_ext;
  logic                    in_range;

  assign even_ext = ADDRESS_BITS'(even_mod);
  assign odd_ext  = ADDRESS_BITS'(odd_mod);
  assign load_ext = ADDRESS_BITS'(wr_value);
  assign in_range = req.plane < NPL;
  assign rd_addr  = in_range ? 24'(ptr_r[req.plane[IW-1:0]]) : 24'd0;

  for (genvar g = 0; g < MAX_PLANES; g++) begin : g_ptr
    localparam logic [2:0] IDX = 3'(g);
    localparam bit         ODD = (g % 2) == 1;
    always_ff @(posedge clk) begin
      if (req.load && req.plane == IDX) begin
        ptr_r[g] <= load_ext;
      end else if (req.bump && req.plane == IDX) begin
        ptr_r[g] <= ptr_r[g] + ADDRESS_BITS'(2);
      end else if (req.new_line && IDX < plane_count) begin
        ptr_r[g] <= ptr_r[g] + (ODD ? odd_ext : even_ext);
      end
    end
  end

endmodule

// File: rtl/bitplane_dma_slot_sequencer_core.sv
`timescale 1ns / 1ps
// bitplane dma slot sequencer top: input register, slot logic, pointer file, result register
// path: an accepted transaction is held in the input register, worked on once the result
//   register can take a new value, and registered there to show on out_tvalid
// throughput: one transaction per cycle, sustained while out_tready stays high
// reset: synchronous active-low rst_n clears handshake state, run flag, slot counter and
//   configuration; plane pointers have no reset and hold garbage until loaded
module bitplane_dma_slot_sequencer_core import bdss_pkg::*; #(
  parameter int MAX_PLANES   = 6,
  parameter int ADDRESS_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // window_open[0], fetch_begin[1], plane_select[4:2], pointer_value[28:5], zero[31:29]
  input  logic [31:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // plane_index[2:0], fetch_address[26:3], slot_used[27], zero[31:28]
  output logic [31:0] out_tdata,
  // action[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] NPL = 3'(MAX_PLANES);

  // configuration registers
  logic               dma_enable_r;
  logic               hires_mode_r;
  logic [2:0]         plane_count_r;
  logic signed [15:0] even_mod_r;
  logic signed [15:0] odd_mod_r;

  // input register
  logic        in_valid_r, in_valid_nxt;
  logic [28:0] in_data_r;
  logic [1:0]  in_user_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  act_t        out_action_r;
  logic [2:0]  out_plane_r;
  logic [23:0] out_addr_r;
  logic        out_used_r;

  logic        advance;   // result register can take a new value
  logic        take;      // the held transaction is worked on this cycle
  cmd_t        cmd;
  logic        is_tick;
  logic [2:0]  count_sat;
  logic [2:0]  count;
  slot_t       slot;
  ptr_req_t    req;
  logic [23:0] rd_addr;

  act_t        res_action;
  logic [2:0]  res_plane;
  logic [23:0] res_addr;
  logic        res_used;

  // handshake: input side frees up whenever the result register moves
  assign advance   = !out_valid_r || out_tready;
  assign take      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : in_valid_r);
  assign out_valid_nxt = take ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  assign cmd     = cmd_t'(in_user_r);
  assign is_tick = cmd == CMD_SLOT_TICK;

  // plane count saturates at six and at the instantiated plane count
  assign count_sat = (plane_count_r > PLANE_LIMIT) ? PLANE_LIMIT : plane_count_r;
  assign count     = (count_sat > NPL) ? NPL : count_sat;

  bdss_slot_ctrl u_slot_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (take && is_tick),
    .dma_enable  (dma_enable_r),
    .hires_mode  (hires_mode_r),
    .plane_count (count),
    .window_open (in_data_r[0]),
    .fetch_begin (in_data_r[1]),
    .slot        (slot)
  );

  // pointer file request: slot bump, line modulo add or direct load
  always_comb begin
    req.bump     = 1'b0;
    req.new_line = 1'b0;
    req.load     = 1'b0;
    req.plane    = slot.plane;
    case (cmd)
      CMD_SLOT_TICK: req.bump = take && slot.used;
      CMD_NEW_LINE:  req.new_line = take;
      CMD_PTR_WRITE: begin
        req.load  = take;
        req.plane = in_data_r[4:2];
      end
      default: req.plane = slot.plane;
    endcase
  end

  bdss_ptr_file #(
    .MAX_PLANES   (MAX_PLANES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_ptr_file (
    .clk         (clk),
    .req         (req),
    .plane_count (count),
    .even_mod    (even_mod_r),
    .odd_mod     (odd_mod_r),
    .wr_value    (in_data_r[28:5]),
    .rd_addr     (rd_addr)
  );

  // only a slot tick produces a nonzero result
  assign res_action = is_tick ? slot.action : ACT_NONE;
  assign res_plane  = is_tick ? slot.plane : 3'd0;
  assign res_used   = is_tick && slot.used;
  assign res_addr   = (is_tick && slot.action == ACT_FETCH) ? rd_addr : 24'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      dma_enable_r  <= 1'b0;
      hires_mode_r  <= 1'b0;
      plane_count_r <= 3'd0;
      even_mod_r    <= 16'sd0;
      odd_mod_r     <= 16'sd0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DMA_ENABLE:  dma_enable_r  <= cfg_wdata[0];
          CFG_HIRES_MODE:  hires_mode_r  <= cfg_wdata[0];
          CFG_PLANE_COUNT: plane_count_r <= cfg_wdata[2:0];
          CFG_EVEN_MOD:    even_mod_r    <= cfg_wdata;
          CFG_ODD_MOD:     odd_mod_r     <= cfg_wdata;
          default:         dma_enable_r  <= dma_enable_r;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[28:0];
      in_user_r <= in_tuser;
    end
    if (take) begin
      out_action_r <= res_action;
      out_plane_r  <= res_plane;
      out_addr_r   <= res_addr;
      out_used_r   <= res_used;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_used_r, out_addr_r, out_plane_r};
  assign out_tuser  = out_action_r;

`ifndef NO_ASSERTIONS
  a_used_has_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_used_r |-> out_action_r != ACT_NONE && out_plane_r < NPL)
    else $error("slot used without an action or with a bad plane");

  a_non_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    take && !is_tick |=> out_action_r == ACT_NONE && !out_used_r &&
      out_plane_r == 3'd0 && out_addr_r == 24'd0)
    else $error("non-tick transaction gave a nonzero result");

  a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled while result side is free");

  a_dma_off_background: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_tick && !dma_enable_r |=> out_action_r == ACT_BACKGROUND && !out_used_r)
    else $error("tick with dma off did not give background");
`endif

endmodule

// File: tb/sv/tb_bitplane_dma_slot_sequencer_core.sv
`timescale 1ns / 1ps
// self-checking testbench for the bitplane dma slot sequencer: directed and random stream traffic
module tb_bitplane_dma_slot_sequencer_core;
  import bdss_pkg::*;

  localparam int NUM_PLANES = 6;

  // plane served by each slot, slot 0 in the low three bits
  localparam logic [23:0] LOWRES_MAP = {3'd0, 3'd4, 3'd2, NO_PLANE, 3'd1, 3'd5, 3'd3, NO_PLANE};
  localparam logic [23:0] HIRES_MAP  = {3'd0, 3'd2, 3'd1, 3'd3, 3'd0, 3'd2, 3'd1, 3'd3};

  // one expected result transaction
  typedef struct {
    act_t        action;
    logic [2:0]  plane;
    logic [23:0] addr;
    logic        used;
  } slot_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  bitplane_dma_slot_sequencer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state: pointer file, run flag and slot counter
  logic [23:0] plane_ptr [NUM_PLANES];
  logic        run_active;
  logic [2:0]  slot_ctr;

  // predictor copy of the configuration registers
  logic        dma_on;
  logic        hires_on;
  logic [2:0]  planes_cfg;
  logic [15:0] even_mod;
  logic [15:0] odd_mod;

  slot_result_t expected_slots[$];
  int          items_sent = 0;
  int          errors = 0;
  logic        quiet = 1'b0;    // no idling on either side in the closing phase
  logic        gaps_on = 1'b1;  // sender gaps allowed for the current line

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous overall limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // random field helpers
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [2:0] rand_sel();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // expected result of one accepted transaction; updates the predictor state
  function automatic slot_result_t predict_slot(input cmd_t cmd, input logic win,
                                                input logic beg, input logic [2:0] sel,
                                                input logic [23:0] val);
    slot_result_t r;
    logic [2:0]   n;
    logic [2:0]   p;
    logic         show;
    logic [15:0]  m;
    r.action = ACT_NONE;
    r.plane  = 3'd0;
    r.addr   = 24'd0;
    r.used   = 1'b0;
    // plane count above the limit saturates
    n = (planes_cfg > PLANE_LIMIT) ? PLANE_LIMIT : planes_cfg;
    case (cmd)
      CMD_SLOT_TICK: begin
        if (dma_on && n != 3'd0) begin
          show = 1'b1;
          // idle: window decides visibility, fetch_begin may start a run
          if (!run_active) begin
            show       = win;
            run_active = beg;
            slot_ctr   = 3'd0;
          end
          if (run_active) begin
            p = hires_on ? HIRES_MAP[slot_ctr*3 +: 3] : LOWRES_MAP[slot_ctr*3 +: 3];
            slot_ctr = slot_ctr + 3'd1;
            if (p < n) begin
              // plane 0 is the last slot of a run
              if (p == 3'd0) run_active = 1'b0;
              r.action = show ? ACT_FETCH : ACT_BACKGROUND;
              r.addr   = show ? plane_ptr[p] : 24'd0;
              r.plane  = p;
              r.used   = 1'b1;
              plane_ptr[p] = plane_ptr[p] + 24'd2;
            end
          end else begin
            r.action = ACT_BACKGROUND;
          end
        end else begin
          r.action = ACT_BACKGROUND;
        end
      end
      CMD_NEW_LINE: begin
        for (int i = 0; i < NUM_PLANES; i++) begin
          if (i < n) begin
            m = i[0] ? odd_mod : even_mod;
            plane_ptr[i] = plane_ptr[i] + {{8{m[15]}}, m};
          end
        end
      end
      CMD_PTR_WRITE: begin
        if (sel < NUM_PLANES) plane_ptr[sel] = val;
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one transaction, wait for its handshake, then queue the prediction
  task automatic send_item(input cmd_t cmd, input logic win, input logic beg,
                           input logic [2:0] sel, input logic [23:0] val);
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, val, sel, beg, win};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_slots.push_back(predict_slot(cmd, win, beg, sel, val));
    items_sent++;
    // valid stays high; the next call or a drain decides what happens at this edge
    @(negedge clk);
  endtask

  // same, with the plane select and pointer value filled at random
  task automatic send_loose(input cmd_t cmd, input logic win, input logic beg);
    logic [23:0] v;
    v = 24'($urandom);
    send_item(cmd, win, beg, rand_sel(), v);
  endtask

  // stop sending and let every expected result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_slots.size() != 0) @(negedge clk);
    // result path is two stages deep
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      CFG_DMA_ENABLE:  dma_on     = data[0];
      CFG_HIRES_MODE:  hires_on   = data[0];
      CFG_PLANE_COUNT: planes_cfg = data[2:0];
      CFG_EVEN_MOD:    even_mod   = data;
      CFG_ODD_MOD:     odd_mod    = data;
      default: ;
    endcase
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic dma, input logic hires, input logic [2:0] planes,
                               input logic [15:0] even, input logic [15:0] odd);
    wait_idle();
    cfg_write(CFG_DMA_ENABLE, {15'd0, dma});
    cfg_write(CFG_HIRES_MODE, {15'd0, hires});
    cfg_write(CFG_PLANE_COUNT, {13'd0, planes});
    cfg_write(CFG_EVEN_MOD, even);
    cfg_write(CFG_ODD_MOD, odd);
  endtask

  // one display line: optional noise item, optional pointer load, idle ticks, a run, then new line
  task automatic random_line();
    logic [23:0] v;
    gaps_on = ($urandom_range(0, 3) != 0);
    // noise: any command, every field random
    if ($urandom_range(0, 7) == 0) begin
      v = 24'($urandom);
      send_item(cmd_t'($urandom_range(0, 3)), rand_bit(), rand_bit(), rand_sel(), v);
    end
    if ($urandom_range(0, 3) == 0) send_loose(CMD_PTR_WRITE, rand_bit(), rand_bit());
    repeat ($urandom_range(0, 2)) send_loose(CMD_SLOT_TICK, rand_bit(), 1'b0);
    // run start, window mostly open
    send_loose(CMD_SLOT_TICK, $urandom_range(0, 4) != 0, 1'b1);
    repeat ($urandom_range(4, 16)) send_loose(CMD_SLOT_TICK, rand_bit(), rand_bit());
    send_loose(CMD_NEW_LINE, rand_bit(), rand_bit());
  endtask

  task automatic run_random_phase(input logic dma, input logic hires, input logic [2:0] planes,
                                  input logic [15:0] even, input logic [15:0] odd,
                                  input int n);
    int stop;
    apply_setting(dma, hires, planes, even, odd);
    stop = items_sent + n;
    while (items_sent < stop) random_line();
  endtask

  // every pointer loaded before anything can read it; out-of-range selects and
  // the reserved command leave state alone; a tick with dma off gives background
  task automatic test_pointer_load();
    send_item(CMD_PTR_WRITE, 1'b0, 1'b0, 3'd0, 24'hFFFFFE);
    send_item(CMD_PTR_WRITE, 1'b1, 1'b1, 3'd1, 24'h000000);
    send_item(CMD_PTR_WRITE, 1'b0, 1'b1, 3'd2, 24'h123456);
    send_item(CMD_PTR_WRITE, 1'b1, 1'b0, 3'd3, 24'hFFFFFF);
    send_item(CMD_PTR_WRITE, 1'b0, 1'b0, 3'd4, 24'hABCDE0);
    send_item(CMD_PTR_WRITE, 1'b0, 1'b0, 3'd5, 24'h555554);
    send_item(CMD_PTR_WRITE, 1'b1, 1'b1, 3'd6, 24'hFFFFFF);
    send_item(CMD_PTR_WRITE, 1'b1, 1'b1, 3'd7, 24'h000000);
    send_item(CMD_RESERVED, 1'b1, 1'b1, 3'd7, 24'hFFFFFF);
    send_item(CMD_SLOT_TICK, 1'b1, 1'b1, 3'd0, 24'h000000);
  endtask

  // full lowres run over all eight slots, counter wrap, pointer wrap and
  // new line with the most negative and most positive modulo
  task automatic test_lowres_run();
    apply_setting(1'b1, 1'b0, 3'd6, 16'h8000, 16'h7FFF);
    send_item(CMD_SLOT_TICK, 1'b0, 1'b0, 3'd0, 24'd0);
    send_item(CMD_SLOT_TICK, 1'b1, 1'b1, 3'd0, 24'd0);
    repeat (7) send_item(CMD_SLOT_TICK, 1'b0, 1'b0, 3'd0, 24'd0);
    send_item(CMD_SLOT_TICK, 1'b1, 1'b0, 3'd0, 24'd0);
    send_item(CMD_NEW_LINE, 1'b0, 1'b0, 3'd0, 24'd0);
  endtask

  // hires run started with the window closed: the opening slot gives a background
  // word, hires slot 3 ends the run; plane count 7 saturates
  task automatic test_hires_background();
    apply_setting(1'b1, 1'b1, 3'd7, 16'h7FFF, 16'h8000);
    send_item(CMD_SLOT_TICK, 1'b0, 1'b1, 3'd0, 24'd0);
    repeat (3) send_item(CMD_SLOT_TICK, 1'b1, 1'b1, 3'd0, 24'd0);
    send_item(CMD_NEW_LINE, 1'b1, 1'b1, 3'd0, 24'd0);
  endtask

  // walk through a spread of settings, extremes included
  task automatic test_setting_sweep();
    run_random_phase(1'b1, 1'b0, 3'd6, rand16(), rand16(), 80);
    run_random_phase(1'b1, 1'b1, 3'd4, rand16(), rand16(), 70);
    run_random_phase(1'b0, 1'b0, 3'd6, rand16(), rand16(), 40);
    run_random_phase(1'b1, 1'b0, 3'd0, rand16(), rand16(), 40);
    run_random_phase(1'b1, 1'b1, 3'd7, 16'h8000, 16'h7FFF, 70);
    run_random_phase(1'b1, 1'b0, 3'd7, 16'h7FFF, 16'h8000, 70);
    run_random_phase(1'b1, 1'b0, 3'd3, rand16(), rand16(), 70);
    run_random_phase(1'b1, 1'b1, 3'd1, rand16(), rand16(), 70);
    run_random_phase(1'b1, 1'b0, 3'd1, rand16(), rand16(), 50);
    run_random_phase(1'b1, 1'b1, 3'd2, rand16(), rand16(), 50);
  endtask

  // sender holds off mid-phase until the result queue is empty
  task automatic test_drain_pause();
    int stop;
    apply_setting(1'b1, 1'b0, 3'd5, rand16(), rand16());
    stop = items_sent + 40;
    while (items_sent < stop) random_line();
    wait_idle();
    stop = items_sent + 40;
    while (items_sent < stop) random_line();
  endtask

  // back-to-back traffic with both sides always ready
  task automatic test_full_rate();
    quiet = 1'b1;
    run_random_phase(1'b1, rand_bit(), 3'd6, rand16(), rand16(), 120);
  endtask

  // result side: random stall bursts, calm stretches in between
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // every result transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_slots.size() == 0) begin
        note_failure("unexpected result", 32'd0, {out_tuser, out_tdata[29:0]});
      end else begin
        want = expected_slots.pop_front();
        if (out_tuser != want.action)
          note_failure("action", 32'(want.action), 32'(out_tuser));
        if (out_tdata[2:0] != want.plane)
          note_failure("plane_index", 32'(want.plane), 32'(out_tdata[2:0]));
        if (out_tdata[26:3] != want.addr)
          note_failure("fetch_address", 32'(want.addr), 32'(out_tdata[26:3]));
        if (out_tdata[27] != want.used)
          note_failure("slot_used", 32'(want.used), 32'(out_tdata[27]));
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 32'd0;
    in_tuser   = CMD_SLOT_TICK;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_DMA_ENABLE;
    cfg_wdata  = 16'd0;
    // predictor starts from the reset state
    run_active = 1'b0;
    slot_ctr   = 3'd0;
    dma_on     = 1'b0;
    hires_on   = 1'b0;
    planes_cfg = 3'd0;
    even_mod   = 16'd0;
    odd_mod    = 16'd0;
    for (int i = 0; i < NUM_PLANES; i++) plane_ptr[i] = 24'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pointer_load();
    test_lowres_run();
    test_hires_background();
    test_setting_sweep();
    test_drain_pause();
    test_full_rate();

    // all results back, then a few extra cycles for anything stray
    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
